### design/voxel_falling_sand_grid_macros.svh
// ----------------------------------------------------------------------------
// Voxel falling-sand grid: assertion macros
// Immediate-implication and next-cycle-implication checks on i_clk.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FALLING_SAND_GRID_MACROS_SVH
`define VOXEL_FALLING_SAND_GRID_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VFSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define VFSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/vfsg_pkg.sv
// ----------------------------------------------------------------------------
// vfsg_pkg
// Operation codes and voxel entry layout for the voxel falling-sand grid.
// ----------------------------------------------------------------------------
package vfsg_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_STEP  = 2'd3;

    typedef struct packed {
        logic       occ;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_voxel;

endpackage

### design/voxel_falling_sand_grid.sv
// A step sweeps (GRID_HEIGHT-1)*GRID_WIDTH*GRID_DEPTH cells through the single-port
// voxel memory, whose reads and writes share one address.
// One word at a time; a write never raises busy, other words hold it until their strobe.
// Reset: synchronous; a clearing pass over all GRID_WIDTH*GRID_HEIGHT*GRID_DEPTH cells follows,
// busy high throughout, no result strobe for it.
// ----------------------------------------------------------------------------
// Voxel falling-sand grid
// 3-D grid of colored voxels with write, read, clear and a sand-fall step,
// run by a small sequencer around one single-port voxel memory.
// ----------------------------------------------------------------------------
`include "voxel_falling_sand_grid_macros.svh"

module voxel_falling_sand_grid
    import vfsg_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32,
    parameter int GRID_DEPTH  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_coord_x,
    input  logic [7:0] i_coord_y,
    input  logic [7:0] i_coord_z,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    output logic       o_valid,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic       o_occupied
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT * GRID_DEPTH;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int ZW    = $clog2(GRID_DEPTH);
    localparam int PLANE = GRID_WIDTH * GRID_HEIGHT;

    localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);
    localparam logic [ZW-1:0] Z_LAST = ZW'(GRID_DEPTH - 1);
    localparam logic [AW-1:0] A_LAST = AW'(CELLS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;  // memory sweep (reset or clear op)
    localparam logic [3:0] S_RDO  = 4'd2;  // read data back, strobe result
    localparam logic [3:0] S_SH   = 4'd3;  // read current cell
    localparam logic [3:0] S_SHW  = 4'd4;  // check current, read cell below
    localparam logic [3:0] S_SBW  = 4'd5;  // check cell below
    localparam logic [3:0] S_SD   = 4'd6;  // pick side neighbor, read its lower cell
    localparam logic [3:0] S_SDL  = 4'd7;  // check lower, read upper side cell
    localparam logic [3:0] S_SDU  = 4'd8;  // check upper side cell
    localparam logic [3:0] S_SW1  = 4'd9;  // swap: target gets moving voxel
    localparam logic [3:0] S_SW2  = 4'd10; // swap: current gets target entry
    localparam logic [3:0] S_NX   = 4'd11; // advance scan position

    logic [3:0]    r_state;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_rpt;   // clear op (strobes) vs reset sweep (silent)
    logic          r_par;
    logic          r_valid;
    logic [1:0]    r_op;
    logic          r_ok;
    t_voxel        r_res;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic [XW-1:0] r_tx;
    logic [ZW-1:0] r_tz;
    logic [1:0]    r_dir;
    t_voxel        r_here;
    t_voxel        r_tdata;
    t_voxel        r_rdata;

    t_voxel        mem [CELLS];

    logic          in_ok;
    logic          even;
    logic          dir_x, dec, nb_ok;
    logic [XW-1:0] nx;
    logic [ZW-1:0] nz;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [ZW-1:0] az;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    t_voxel        mem_wdata;

    assign in_ok = (9'(i_coord_x) < 9'(GRID_WIDTH)) && (9'(i_coord_y) < 9'(GRID_HEIGHT))
                && (9'(i_coord_z) < 9'(GRID_DEPTH));

    // frame is even when parity is zero after the flip; then p = -1
    assign even = !r_par;

    // dirs: 0 (x+p), 1 (z+p), 2 (x-p), 3 (z-p)
    always_comb begin
        dir_x = !r_dir[0];
        dec   = r_dir[1] ? !even : even;
        nx    = r_x;
        nz    = r_z;
        if (dir_x) begin
            nb_ok = dec ? (r_x != '0) : (r_x != X_LAST);
            nx    = dec ? r_x - 1'b1 : r_x + 1'b1;
        end else begin
            nb_ok = dec ? (r_z != '0) : (r_z != Z_LAST);
            nz    = dec ? r_z - 1'b1 : r_z + 1'b1;
        end
    end

    // memory address / write control
    always_comb begin
        ax        = r_x;
        ay        = r_y;
        az        = r_z;
        mem_we    = 1'b0;
        mem_wdata = r_here;
        unique case (r_state)
            S_IDLE: begin
                ax     = XW'(i_coord_x);
                ay     = YW'(i_coord_y);
                az     = ZW'(i_coord_z);
                mem_we = start && (i_operation == OP_WRITE) && in_ok;
                mem_wdata = '{occ: 1'b1, red: i_red_in, green: i_green_in, blue: i_blue_in};
            end
            S_SHW:  ay = r_y - 1'b1;
            S_SD: begin
                ax = nx;
                ay = r_y - 1'b1;
                az = nz;
            end
            S_SDL: begin
                ax = nx;
                az = nz;
            end
            S_SW1: begin
                ax     = r_tx;
                ay     = r_y - 1'b1;
                az     = r_tz;
                mem_we = 1'b1;
            end
            S_SW2: begin
                mem_we    = 1'b1;
                mem_wdata = r_tdata;
            end
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            default: ;
        endcase
        if (r_state == S_CLR) begin
            mem_addr = r_clr_addr;
        end else begin
            mem_addr = AW'(32'(ax) + 32'(ay) * GRID_WIDTH + 32'(az) * PLANE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_rpt  <= 1'b0;
            r_par      <= 1'b0;
            r_valid    <= 1'b0;
            r_op       <= OP_WRITE;
            r_ok       <= 1'b0;
            r_dir      <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op <= i_operation;
                        r_ok <= in_ok;
                        unique case (i_operation)
                            OP_WRITE: begin
                                r_valid <= 1'b1;
                                r_res   <= '0;
                            end
                            OP_READ:  r_state <= S_RDO;
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_rpt  <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            OP_STEP: begin
                                // new parity is ~r_par; even when that is zero
                                r_par   <= ~r_par;
                                r_y     <= YW'(1);
                                r_x     <= r_par ? '0 : X_LAST;
                                r_z     <= r_par ? '0 : Z_LAST;
                                r_state <= S_SH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_clr_addr == A_LAST) begin
                        r_state <= S_IDLE;
                        r_valid <= r_clr_rpt;
                        r_res   <= '0;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_RDO: begin
                    r_valid <= 1'b1;
                    r_res   <= r_ok ? r_rdata : '0;
                    r_state <= S_IDLE;
                end
                S_SH:  r_state <= S_SHW;
                S_SHW: begin
                    r_here  <= r_rdata;
                    r_state <= r_rdata.occ ? S_SBW : S_NX;
                end
                S_SBW: begin
                    if (!r_rdata.occ) begin
                        r_tx    <= r_x;
                        r_tz    <= r_z;
                        r_tdata <= r_rdata;
                        r_state <= S_SW1;
                    end else begin
                        r_dir   <= '0;
                        r_state <= S_SD;
                    end
                end
                S_SD: begin
                    if (nb_ok) begin
                        r_state <= S_SDL;
                    end else if (r_dir == 2'd3) begin
                        r_state <= S_NX;
                    end else begin
                        r_dir <= r_dir + 1'b1;
                    end
                end
                S_SDL: begin
                    if (!r_rdata.occ) begin
                        r_tdata <= r_rdata;
                        r_state <= S_SDU;
                    end else if (r_dir == 2'd3) begin
                        r_state <= S_NX;
                    end else begin
                        r_dir   <= r_dir + 1'b1;
                        r_state <= S_SD;
                    end
                end
                S_SDU: begin
                    if (!r_rdata.occ) begin
                        r_tx    <= nx;
                        r_tz    <= nz;
                        r_state <= S_SW1;
                    end else if (r_dir == 2'd3) begin
                        r_state <= S_NX;
                    end else begin
                        r_dir   <= r_dir + 1'b1;
                        r_state <= S_SD;
                    end
                end
                S_SW1: r_state <= S_SW2;
                S_SW2: r_state <= S_NX;
                S_NX: begin
                    r_state <= S_SH;
                    if (r_x != (even ? X_LAST : '0)) begin
                        r_x <= even ? r_x + 1'b1 : r_x - 1'b1;
                    end else begin
                        r_x <= even ? '0 : X_LAST;
                        if (r_z != (even ? Z_LAST : '0)) begin
                            r_z <= even ? r_z + 1'b1 : r_z - 1'b1;
                        end else begin
                            r_z <= even ? '0 : Z_LAST;
                            if (r_y == Y_LAST) begin
                                r_valid <= 1'b1;
                                r_res   <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_y <= r_y + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_red_out   = r_res.red;
    assign o_green_out = r_res.green;
    assign o_blue_out  = r_res.blue;
    assign o_occupied  = r_res.occ;

    `VFSG_ASSERT_NOW(a_nonread_zero, o_valid && (r_op != OP_READ), r_res == '0, "nonzero result word for non-read")
    `VFSG_ASSERT_NOW(a_empty_nocolor, o_valid && !o_occupied, r_res == '0, "empty voxel carries color")
    `VFSG_ASSERT_NEXT(a_step_busy, start && !busy && (i_operation == OP_STEP), busy, "step did not raise busy")
    `VFSG_ASSERT_NEXT(a_swap_pair, r_state == S_SW1, r_state == S_SW2, "swap half done")

endmodule

### bench/voxel_falling_sand_grid_tb.sv
// ----------------------------------------------------------------------------
// voxel_falling_sand_grid_tb
// Self-checking bench for the voxel falling-sand grid. It sends write, read,
// clear and step words through the start/busy handshake, with bursts and
// gaps. A behavioral copy of the grid predicts every result word, and the
// monitor checks each strobed word, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module voxel_falling_sand_grid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfsg_pkg::*;

    localparam int GW    = 32;
    localparam int GH    = 32;
    localparam int GD    = 32;
    localparam int CELLS = GW * GH * GD;

    // one command word, plus a flag that holds it back until all results are in
    typedef struct {
        logic [1:0] op;
        logic [7:0] x, y, z;
        logic [7:0] r, g, b;
        bit         hold;
    } t_cmd;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic [1:0] i_operation = OP_WRITE;
    logic [7:0] i_coord_x   = '0;
    logic [7:0] i_coord_y   = '0;
    logic [7:0] i_coord_z   = '0;
    logic [7:0] i_red_in    = '0;
    logic [7:0] i_green_in  = '0;
    logic [7:0] i_blue_in   = '0;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_red_out, o_green_out, o_blue_out;
    logic       o_occupied;

    voxel_falling_sand_grid #(
        .GRID_WIDTH (GW),
        .GRID_HEIGHT(GH),
        .GRID_DEPTH (GD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operation(i_operation),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_coord_z  (i_coord_z),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .o_valid    (o_valid),
        .o_red_out  (o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out (o_blue_out),
        .o_occupied (o_occupied)
    );

    // ---------------------------------------------------------------- shadow grid
    t_voxel grid_mirror [CELLS];
    bit     parity_mirror;

    t_cmd   cmd_q [$];        // words still to send
    t_voxel readback_q [$];   // predicted result words, oldest first
    int     errors;

    function automatic int cell_idx(int x, int y, int z);
        return x + y * GW + z * GW * GH;
    endfunction

    function automatic bit in_grid(int x, int y, int z);
        return x >= 0 && x < GW && y >= 0 && y < GH && z >= 0 && z < GD;
    endfunction

    function automatic bit is_full(int x, int y, int z);
        if (!in_grid(x, y, z)) return 1'b0;
        return grid_mirror[cell_idx(x, y, z)].occ;
    endfunction

    function automatic void swap_cells(int a, int c);
        t_voxel t;
        t = grid_mirror[a];
        grid_mirror[a] = grid_mirror[c];
        grid_mirror[c] = t;
    endfunction

    // one grain: straight down first, then the four side-down spots in order
    function automatic void settle_grain(int x, int y, int z, int p);
        int dx [4];
        int dz [4];
        int nx, nz;
        int here;
        here = cell_idx(x, y, z);
        if (!grid_mirror[here].occ) return;
        if (!is_full(x, y - 1, z)) begin
            swap_cells(here, cell_idx(x, y - 1, z));
            return;
        end
        dx = '{p, 0, -p, 0};
        dz = '{0, p, 0, -p};
        for (int d = 0; d < 4; d++) begin
            nx = x + dx[d];
            nz = z + dz[d];
            if (in_grid(nx, y - 1, nz) && !is_full(nx, y - 1, nz) && !is_full(nx, y, nz)) begin
                swap_cells(here, cell_idx(nx, y - 1, nz));
                return;
            end
        end
    endfunction

    // in-place sweep; direction of z/x and the side preference follow parity
    function automatic void sand_step();
        bit even;
        int p, z, x;
        parity_mirror = ~parity_mirror;
        even = (parity_mirror == 1'b0);
        p = even ? -1 : 1;
        for (int y = 1; y < GH; y++)
            for (int i = 0; i < GD; i++) begin
                z = even ? i : GD - 1 - i;
                for (int j = 0; j < GW; j++) begin
                    x = even ? j : GW - 1 - j;
                    settle_grain(x, y, z, p);
                end
            end
    endfunction

    function automatic void clear_mirror();
        foreach (grid_mirror[k]) grid_mirror[k] = '0;
    endfunction

    // applies one accepted word to the shadow grid, returns the predicted result
    function automatic t_voxel apply_word(t_cmd c);
        t_voxel res;
        bit     ok;
        res = '0;
        ok = in_grid(c.x, c.y, c.z);
        case (c.op)
            OP_WRITE: if (ok) grid_mirror[cell_idx(c.x, c.y, c.z)] = '{1'b1, c.r, c.g, c.b};
            OP_READ:  if (ok) res = grid_mirror[cell_idx(c.x, c.y, c.z)];
            OP_CLEAR: clear_mirror();
            default:  sand_step();
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- clock, reset
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- driver
    // Bursts of random length, random gaps between them. A word flagged hold
    // waits until every predicted result has been seen.
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_cmd nxt;
        bit   drive;
        drive = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                void'(cmd_q.pop_front());
                readback_q.push_back(apply_word('{i_operation, i_coord_x, i_coord_y,
                    i_coord_z, i_red_in, i_green_in, i_blue_in, 1'b0}));
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    // some bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else if (!start && gap_left > 0) begin
                gap_left--;
            end
            if (gap_left == 0 && cmd_q.size() > 0) begin
                nxt = cmd_q[0];
                drive = !(nxt.hold && readback_q.size() != 0 && !(start && !busy));
                if (nxt.hold && readback_q.size() != 0) drive = 1'b0;
                if (drive) begin
                    i_operation <= nxt.op;
                    i_coord_x   <= nxt.x;
                    i_coord_y   <= nxt.y;
                    i_coord_z   <= nxt.z;
                    i_red_in    <= nxt.r;
                    i_green_in  <= nxt.g;
                    i_blue_in   <= nxt.b;
                end
            end
        end
        start <= drive;
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_voxel want;
        if (i_rst_n && o_valid) begin
            if (readback_q.size() == 0) begin
                $display("%0t: unexpected result word red=%0d green=%0d blue=%0d occ=%0d",
                         $time, o_red_out, o_green_out, o_blue_out, o_occupied);
                errors++;
            end else begin
                want = readback_q.pop_front();
                if (o_red_out !== want.red) begin
                    $display("%0t: red mismatch expected %0d actual %0d",
                             $time, want.red, o_red_out);
                    errors++;
                end
                if (o_green_out !== want.green) begin
                    $display("%0t: green mismatch expected %0d actual %0d",
                             $time, want.green, o_green_out);
                    errors++;
                end
                if (o_blue_out !== want.blue) begin
                    $display("%0t: blue mismatch expected %0d actual %0d",
                             $time, want.blue, o_blue_out);
                    errors++;
                end
                if (o_occupied !== want.occ) begin
                    $display("%0t: occupied mismatch expected %0d actual %0d",
                             $time, want.occ, o_occupied);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_cmd(logic [1:0] op, int x, int y, int z,
                           int r = 0, int g = 0, int b = 0, bit hold = 0);
        t_cmd c;
        c = '{op, x[7:0], y[7:0], z[7:0], r[7:0], g[7:0], b[7:0], hold};
        cmd_q.push_back(c);
    endtask

    // noise: any coordinates, mostly off the grid, any color
    task automatic add_noise();
        logic [1:0] op;
        op = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
        add_cmd(op, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    initial begin
        int bx, bz, span;

        errors = 0;
        clear_mirror();
        parity_mirror = 1'b0;

        // directed: corners, color extremes, off-grid on each axis
        add_cmd(OP_WRITE, 0, 0, 0, 255, 0, 255);
        add_cmd(OP_WRITE, 31, 31, 31, 0, 255, 0);
        add_cmd(OP_WRITE, 32, 5, 5, 1, 2, 3);
        add_cmd(OP_WRITE, 5, 255, 5, 1, 2, 3);
        add_cmd(OP_WRITE, 5, 5, 32, 1, 2, 3);
        add_cmd(OP_READ, 0, 0, 0);
        add_cmd(OP_READ, 31, 31, 31);
        add_cmd(OP_READ, 255, 0, 0);
        add_cmd(OP_READ, 7, 7, 7);            // empty cell
        // short column, a grain on the grid edge, one resting on another
        add_cmd(OP_WRITE, 5, 0, 5, 10, 20, 30);
        add_cmd(OP_WRITE, 5, 1, 5, 40, 50, 60);
        add_cmd(OP_WRITE, 5, 2, 5, 70, 80, 90);
        add_cmd(OP_WRITE, 0, 1, 0, 11, 22, 33);
        add_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 1);  // sender drains first
        add_cmd(OP_READ, 5, 0, 5);
        add_cmd(OP_READ, 5, 1, 5);
        add_cmd(OP_READ, 4, 0, 5);
        add_cmd(OP_READ, 6, 0, 5);
        add_cmd(OP_READ, 31, 30, 31);
        add_cmd(OP_READ, 0, 1, 0);
        add_cmd(OP_CLEAR, 0, 0, 0);
        add_cmd(OP_READ, 0, 0, 0);
        add_cmd(OP_READ, 5, 0, 5);

        // random: fill a small box, step (even, odd, even frame), read it back
        for (int round = 0; round < 3; round++) begin
            span = $urandom_range(3, 6);
            case ($urandom_range(0, 2))
                0: begin bx = 0;       bz = 0;       end
                1: begin bx = GW - span; bz = GD - span; end
                default: begin bx = $urandom_range(0, GW - span); bz = $urandom_range(0, GD - span); end
            endcase
            if (round == 1) add_cmd(OP_CLEAR, 0, 0, 0);
            for (int n = 0; n < 260; n++) begin
                if ($urandom_range(0, 9) == 0) add_noise();
                else if ($urandom_range(0, 4) == 0)
                    add_cmd(OP_READ, bx + $urandom_range(0, span - 1), $urandom_range(0, GH - 1),
                            bz + $urandom_range(0, span - 1));
                else
                    add_cmd(OP_WRITE, bx + $urandom_range(0, span - 1), $urandom_range(0, 12),
                            bz + $urandom_range(0, span - 1), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255));
            end
            add_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, round == 0);
            for (int n = 0; n < 340; n++) begin
                if ($urandom_range(0, 11) == 0) add_noise();
                else
                    add_cmd(OP_READ, bx - 1 + $urandom_range(0, span + 1), $urandom_range(0, 13),
                            bz - 1 + $urandom_range(0, span + 1));
            end
        end

        while (cmd_q.size() != 0 || start) @(negedge i_clk);
        while (readback_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0)
            $display("voxel_falling_sand_grid regression: pass");
        else
            $display("voxel_falling_sand_grid regression: fail");
        $finish;
    end

    // watchdog: sized for the worst case, the four full-grid steps of the run
    initial begin
        #80ms;
        $display("voxel_falling_sand_grid regression: fail");
        $finish;
    end

endmodule
